>>> hdl/lcdns_pkg.sv
package lcdns_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int WAIT_W      = 16;
    localparam int STEP_W      = 4;

    localparam logic [2:0] OP_COMMAND = 3'd0;
    localparam logic [2:0] OP_DATA    = 3'd1;
    localparam logic [2:0] OP_CURSOR  = 3'd2;
    localparam logic [2:0] OP_CLEAR   = 3'd3;
    localparam logic [2:0] OP_INIT    = 3'd4;

    localparam logic [CFG_INDEX_W-1:0] REG_POWER_ON_WAIT    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_INIT_WAIT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SECOND_INIT_WAIT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CLEAR_WAIT       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ENABLE_PULSE_LEN = 3'd4;

    localparam logic [WAIT_W-1:0] RST_POWER_ON_WAIT    = 16'd50000;
    localparam logic [WAIT_W-1:0] RST_FIRST_INIT_WAIT  = 16'd5000;
    localparam logic [WAIT_W-1:0] RST_SECOND_INIT_WAIT = 16'd150;
    localparam logic [WAIT_W-1:0] RST_CLEAR_WAIT       = 16'd2000;

    localparam logic [7:0] CMD_CLEAR      = 8'h01;
    localparam logic [7:0] CMD_DDRAM      = 8'h80;
    localparam logic [6:0] ROW_ONE_OFFSET = 7'h40;

    localparam logic [STEP_W-1:0] STEP_FIRST      = 4'd0;
    localparam logic [STEP_W-1:0] STEP_SECOND     = 4'd1;
    localparam logic [STEP_W-1:0] BYTE_LAST_STEP  = 4'd1;
    localparam logic [STEP_W-1:0] INIT_LAST_STEP  = 4'd11;

    typedef struct packed {
        logic       is_init;
        logic       rs;
        logic       clr;
        logic [7:0] data_byte;
    } desc_t;

    typedef struct packed {
        logic [WAIT_W-1:0] power_on_wait;
        logic [WAIT_W-1:0] first_init_wait;
        logic [WAIT_W-1:0] second_init_wait;
        logic [WAIT_W-1:0] clear_wait;
    } waits_t;

    function automatic logic [3:0] init_nibble(input logic [STEP_W-1:0] step);
        logic [3:0] nib;
        unique case (step)
            4'd0:    nib = 4'h3;
            4'd1:    nib = 4'h3;
            4'd2:    nib = 4'h3;
            4'd3:    nib = 4'h2;
            4'd4:    nib = 4'h2;
            4'd5:    nib = 4'h8;
            4'd6:    nib = 4'h0;
            4'd7:    nib = 4'hC;
            4'd8:    nib = 4'h0;
            4'd9:    nib = 4'h6;
            4'd10:   nib = 4'h0;
            4'd11:   nib = 4'h1;
            default: nib = 4'h0;
        endcase
        return nib;
    endfunction

endpackage

>>> hdl/lcdns_front.sv
module lcdns_front
    import lcdns_pkg::*;
(
    input  logic [2:0] opcode,
    input  logic [7:0] byte_value,
    input  logic       row,
    input  logic [5:0] column,
    output logic       keep,
    output desc_t      desc
);

    logic [6:0] addr;

    assign addr = {1'b0, column} + (row ? ROW_ONE_OFFSET : 7'd0);

    always_comb
    begin
        keep           = 1'b1;
        desc.is_init   = 1'b0;
        desc.rs        = 1'b0;
        desc.clr       = 1'b0;
        desc.data_byte = byte_value;
        unique case (opcode)
            OP_COMMAND:
            begin
            end
            OP_DATA:
            begin
                desc.rs = 1'b1;
            end
            OP_CURSOR:
            begin
                desc.data_byte = CMD_DDRAM | {1'b0, addr};
            end
            OP_CLEAR:
            begin
                desc.clr       = 1'b1;
                desc.data_byte = CMD_CLEAR;
            end
            OP_INIT:
            begin
                desc.is_init = 1'b1;
            end
            default:
            begin
                // drop unused opcodes
                keep = 1'b0;
            end
        endcase
    end

endmodule

>>> hdl/lcdns_queue.sv
module lcdns_queue
    import lcdns_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  desc_t push_data,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output desc_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    desc_t              mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> hdl/lcdns_back.sv
module lcdns_back
    import lcdns_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  waits_t            waits,
    input  logic              head_valid,
    input  desc_t             head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              reg_select,
    output logic              read_write,
    output logic [3:0]        nibble,
    output logic [WAIT_W-1:0] wait_before,
    output logic [WAIT_W-1:0] wait_after,
    output logic              last
);

    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic              rs_reg;
    logic [3:0]        nibble_reg;
    logic [WAIT_W-1:0] wb_reg, wa_reg;
    logic              last_reg;

    logic              advance, last_step;
    logic [3:0]        nib_cur;
    logic [WAIT_W-1:0] wb_cur, wa_cur;

    assign advance   = head_valid && (!out_valid_reg || out_ready);
    assign last_step = head.is_init ? (step_reg == INIT_LAST_STEP)
                                    : (step_reg == BYTE_LAST_STEP);
    assign pop       = advance && last_step;

    always_comb
    begin
        wb_cur = '0;
        wa_cur = '0;
        if (head.is_init)
        begin
            nib_cur = init_nibble(step_reg);
            if (step_reg == STEP_FIRST)
            begin
                wb_cur = waits.power_on_wait;
                wa_cur = waits.first_init_wait;
            end
            else if (step_reg == STEP_SECOND)
            begin
                wa_cur = waits.second_init_wait;
            end
            else if (step_reg == INIT_LAST_STEP)
            begin
                wa_cur = waits.clear_wait;
            end
        end
        else
        begin
            nib_cur = step_reg[0] ? head.data_byte[3:0] : head.data_byte[7:4];
            if (step_reg == BYTE_LAST_STEP && head.clr)
            begin
                wa_cur = waits.clear_wait;
            end
        end
    end

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            step_next      = last_step ? STEP_FIRST : step_reg + 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rs_reg     <= head.rs;
            nibble_reg <= nib_cur;
            wb_reg     <= wb_cur;
            wa_reg     <= wa_cur;
            last_reg   <= last_step;
        end
    end

    assign out_valid   = out_valid_reg;
    assign reg_select  = rs_reg;
    assign read_write  = 1'b0;
    assign nibble      = nibble_reg;
    assign wait_before = wb_reg;
    assign wait_after  = wa_reg;
    assign last        = last_reg;

endmodule

>>> hdl/char_lcd_nibble_sequencer_unit.sv
// Expands display requests (command byte, data byte, cursor move, clear, init) into
// 4-bit bus transfers, high nibble first, one transfer per clock while out_ready
// stays high. A command, data, cursor or clear request gives 2 transfers; init
// gives 12 transfers; the back-end step counter, which walks each request one
// nibble per cycle while out_ready is high, sets this. Requests with an unused
// opcode are accepted and give no transfer. The front end takes a new request
// every cycle while the QUEUE_DEPTH-entry request queue has room, so requests
// may arrive back to back while earlier ones are still being sent.
// An accepted request is registered in the queue, then in the back-end outputs.
module char_lcd_nibble_sequencer_unit
    import lcdns_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [WAIT_W-1:0]      cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [2:0]             opcode,
    input  logic [7:0]             byte_value,
    input  logic                   row,
    input  logic [5:0]             column,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   reg_select,
    output logic                   read_write,
    output logic [3:0]             nibble,
    output logic [WAIT_W-1:0]      wait_before,
    output logic [WAIT_W-1:0]      wait_after,
    output logic                   last
);

    waits_t waits_reg, waits_next;
    desc_t  front_desc, head;
    logic   keep, full, push, pop, head_valid;

    always_comb
    begin
        waits_next = waits_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POWER_ON_WAIT:    waits_next.power_on_wait    = cfg_data;
                REG_FIRST_INIT_WAIT:  waits_next.first_init_wait  = cfg_data;
                REG_SECOND_INIT_WAIT: waits_next.second_init_wait = cfg_data;
                REG_CLEAR_WAIT:       waits_next.clear_wait       = cfg_data;
                REG_ENABLE_PULSE_LEN:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waits_reg.power_on_wait    <= RST_POWER_ON_WAIT;
            waits_reg.first_init_wait  <= RST_FIRST_INIT_WAIT;
            waits_reg.second_init_wait <= RST_SECOND_INIT_WAIT;
            waits_reg.clear_wait       <= RST_CLEAR_WAIT;
        end
        else
        begin
            waits_reg <= waits_next;
        end
    end

    assign in_ready = !full;
    assign push     = in_valid && in_ready && keep;

    lcdns_front u_front (
        .opcode     (opcode),
        .byte_value (byte_value),
        .row        (row),
        .column     (column),
        .keep       (keep),
        .desc       (front_desc)
    );

    lcdns_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (front_desc),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    lcdns_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .waits       (waits_reg),
        .head_valid  (head_valid),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .reg_select  (reg_select),
        .read_write  (read_write),
        .nibble      (nibble),
        .wait_before (wait_before),
        .wait_after  (wait_after),
        .last        (last)
    );

endmodule

>>> verif/char_lcd_nibble_sequencer_unit_tb.sv
module char_lcd_nibble_sequencer_unit_tb;
    import lcdns_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_CYCLES = 20;
    localparam int MAX_REPORTS  = 10;
    localparam int PHASE_ITEMS  = 50;

    localparam logic [3:0] NIB_WAKE     = 4'h3;
    localparam logic [3:0] NIB_4BIT     = 4'h2;
    localparam logic [7:0] CMD_FUNC_SET = 8'h28;
    localparam logic [7:0] CMD_DISP_ON  = 8'h0C;
    localparam logic [7:0] CMD_ENTRY    = 8'h06;
    localparam logic [WAIT_W-1:0] RST_ENABLE_PULSE_LEN = 16'd1000;
    localparam logic [WAIT_W-1:0] WAIT_MAX = 16'hFFFF;
    localparam logic [WAIT_W-1:0] WAIT_MIN = 16'h0000;

    localparam logic [2:0] OP_RESERVED_LO = 3'd5;
    localparam logic [2:0] OP_RESERVED_HI = 3'd7;

    typedef struct packed {
        logic              rs;
        logic              rw;
        logic [3:0]        nib;
        logic [WAIT_W-1:0] wb;
        logic [WAIT_W-1:0] wa;
        logic              last;
    } transfer_t;

    class lcd_transfer_scoreboard;
        transfer_t         expected_q[$];
        logic [WAIT_W-1:0] power_on_wait;
        logic [WAIT_W-1:0] first_init_wait;
        logic [WAIT_W-1:0] second_init_wait;
        logic [WAIT_W-1:0] clear_wait;
        logic [WAIT_W-1:0] pulse_len;
        int                errors;

        function new();
            errors = 0;
            set_config(RST_POWER_ON_WAIT, RST_FIRST_INIT_WAIT, RST_SECOND_INIT_WAIT,
                       RST_CLEAR_WAIT, RST_ENABLE_PULSE_LEN);
        endfunction

        function void set_config(logic [WAIT_W-1:0] pow, logic [WAIT_W-1:0] first,
                                 logic [WAIT_W-1:0] second, logic [WAIT_W-1:0] clr,
                                 logic [WAIT_W-1:0] pulse);
            power_on_wait    = pow;
            first_init_wait  = first;
            second_init_wait = second;
            clear_wait       = clr;
            pulse_len        = pulse;
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
        endfunction

        function void push_nibble(logic rs, logic [3:0] nib, logic [WAIT_W-1:0] wb,
                                  logic [WAIT_W-1:0] wa);
            transfer_t t;
            t.rs   = rs;
            t.rw   = 1'b0;
            t.nib  = nib;
            t.wb   = wb;
            t.wa   = wa;
            t.last = 1'b0;
            expected_q.push_back(t);
        endfunction

        function void push_byte(logic rs, logic [7:0] b, logic [WAIT_W-1:0] wa);
            push_nibble(rs, b[7:4], WAIT_MIN, WAIT_MIN);
            push_nibble(rs, b[3:0], WAIT_MIN, wa);
        endfunction

        function void note_request(logic [2:0] op, logic [7:0] b, logic r, logic [5:0] col);
            logic [6:0] addr;
            int         before_n;
            before_n = expected_q.size();
            addr = {1'b0, col} + (r ? ROW_ONE_OFFSET : 7'h00);
            case (op)
                OP_COMMAND: push_byte(1'b0, b, WAIT_MIN);
                OP_DATA:    push_byte(1'b1, b, WAIT_MIN);
                OP_CURSOR:  push_byte(1'b0, CMD_DDRAM | {1'b0, addr}, WAIT_MIN);
                OP_CLEAR:   push_byte(1'b0, CMD_CLEAR, clear_wait);
                OP_INIT:
                begin
                    push_nibble(1'b0, NIB_WAKE, power_on_wait, first_init_wait);
                    push_nibble(1'b0, NIB_WAKE, WAIT_MIN, second_init_wait);
                    push_nibble(1'b0, NIB_WAKE, WAIT_MIN, WAIT_MIN);
                    push_nibble(1'b0, NIB_4BIT, WAIT_MIN, WAIT_MIN);
                    push_byte(1'b0, CMD_FUNC_SET, WAIT_MIN);
                    push_byte(1'b0, CMD_DISP_ON, WAIT_MIN);
                    push_byte(1'b0, CMD_ENTRY, WAIT_MIN);
                    push_byte(1'b0, CMD_CLEAR, clear_wait);
                end
                default: ;
            endcase
            if (expected_q.size() > before_n)
                expected_q[expected_q.size() - 1].last = 1'b1;
        endfunction

        function void check_transfer(transfer_t got);
            transfer_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected transfer rs=%0d rw=%0d nib=%h wb=%0d wa=%0d last=%0d",
                                 got.rs, got.rw, got.nib, got.wb, got.wa, got.last));
                return;
            end
            want = expected_q.pop_front();
            if (got !== want)
                report($sformatf({"exp rs=%0d rw=%0d nib=%h wb=%0d wa=%0d last=%0d, ",
                                  "got rs=%0d rw=%0d nib=%h wb=%0d wa=%0d last=%0d"},
                                 want.rs, want.rw, want.nib, want.wb, want.wa, want.last,
                                 got.rs, got.rw, got.nib, got.wb, got.wa, got.last));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [WAIT_W-1:0]      cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [2:0]             opcode = '0;
    logic [7:0]             byte_value = '0;
    logic                   row = 1'b0;
    logic [5:0]             column = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   reg_select;
    logic                   read_write;
    logic [3:0]             nibble;
    logic [WAIT_W-1:0]      wait_before;
    logic [WAIT_W-1:0]      wait_after;
    logic                   last;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycle_count    = 0;

    lcd_transfer_scoreboard sb = new();

    char_lcd_nibble_sequencer_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .byte_value (byte_value),
        .row        (row),
        .column     (column),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .reg_select (reg_select),
        .read_write (read_write),
        .nibble     (nibble),
        .wait_before(wait_before),
        .wait_after (wait_after),
        .last       (last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_request(opcode, byte_value, row, column);
            if (out_valid && out_ready)
                sb.check_transfer({reg_select, read_write, nibble, wait_before, wait_after,
                                   last});
        end
    end

    task automatic send_request(input logic [2:0] op, input logic [7:0] b, input logic r,
                                input logic [5:0] col);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        byte_value <= b;
        row        <= r;
        column     <= col;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // drop valid and wait until the block has nothing left to emit
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic [WAIT_W-1:0] pow, input logic [WAIT_W-1:0] first,
                                input logic [WAIT_W-1:0] second,
                                input logic [WAIT_W-1:0] clr,
                                input logic [WAIT_W-1:0] pulse);
        cfg_we    <= 1'b1;
        cfg_index <= REG_POWER_ON_WAIT;
        cfg_data  <= pow;
        @(posedge clk);
        cfg_index <= REG_FIRST_INIT_WAIT;
        cfg_data  <= first;
        @(posedge clk);
        cfg_index <= REG_SECOND_INIT_WAIT;
        cfg_data  <= second;
        @(posedge clk);
        cfg_index <= REG_CLEAR_WAIT;
        cfg_data  <= clr;
        @(posedge clk);
        cfg_index <= REG_ENABLE_PULSE_LEN;
        cfg_data  <= pulse;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_config(pow, first, second, clr, pulse);
    endtask

    task automatic send_random_requests(input int count);
        int         sent;
        int         pick;
        logic [2:0] op;
        logic [5:0] col;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 20)
                op = OP_COMMAND;
            else if (pick < 45)
                op = OP_DATA;
            else if (pick < 65)
                op = OP_CURSOR;
            else if (pick < 75)
                op = OP_CLEAR;
            else if (pick < 88)
                op = OP_INIT;
            else
                op = 3'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));
            if ($urandom_range(0, 3) == 0)
                col = 6'($urandom_range(0, 63));
            else
                col = 6'($urandom_range(0, 39));
            send_request(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), col);
            sent++;
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values, back-to-back requests
        send_request(OP_INIT, 8'h00, 1'b0, 6'd0);
        send_request(OP_COMMAND, 8'h00, 1'b0, 6'd0);
        send_request(OP_COMMAND, 8'hFF, 1'b1, 6'd63);
        send_request(OP_COMMAND, 8'hA5, 1'b0, 6'd21);
        send_request(OP_DATA, 8'h00, 1'b1, 6'd0);
        send_request(OP_DATA, 8'hFF, 1'b0, 6'd63);
        send_request(OP_DATA, 8'h5A, 1'b1, 6'd42);
        send_request(OP_CURSOR, 8'h00, 1'b0, 6'd0);
        send_request(OP_CURSOR, 8'hFF, 1'b1, 6'd39);
        send_request(OP_CURSOR, 8'h00, 1'b0, 6'd39);
        send_request(OP_CURSOR, 8'h00, 1'b1, 6'd0);
        send_request(OP_CURSOR, 8'h00, 1'b1, 6'd63);
        send_request(OP_CURSOR, 8'h00, 1'b0, 6'd40);
        send_request(OP_CURSOR, 8'h00, 1'b1, 6'd42);
        send_request(OP_CLEAR, 8'h00, 1'b0, 6'd0);
        send_request(OP_RESERVED_LO, 8'hFF, 1'b1, 6'd63);
        send_request(OP_RESERVED_LO + 3'd1, 8'h3C, 1'b0, 6'd5);
        send_request(OP_RESERVED_HI, 8'h00, 1'b1, 6'd0);
        send_request(OP_COMMAND, 8'h3C, 1'b0, 6'd0);
        send_request(OP_DATA, 8'hC3, 1'b0, 6'd0);
        send_request(OP_INIT, 8'hFF, 1'b1, 6'd63);
        drain();

        write_config(WAIT_MIN, WAIT_MIN, WAIT_MIN, WAIT_MIN, WAIT_MIN);
        send_request(OP_INIT, 8'h00, 1'b0, 6'd0);
        send_request(OP_CLEAR, 8'h00, 1'b0, 6'd0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_random_requests(PHASE_ITEMS);
        drain();

        write_config(WAIT_MAX, WAIT_MAX, WAIT_MAX, WAIT_MAX, WAIT_MAX);
        send_idle_pct  = 60;
        recv_stall_pct = 0;
        send_request(OP_INIT, 8'h00, 1'b0, 6'd0);
        send_random_requests(PHASE_ITEMS);
        drain();

        write_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(1, 65535)));
        send_idle_pct  = 0;
        recv_stall_pct = 60;
        send_random_requests(PHASE_ITEMS);
        drain();

        write_config(16'($urandom_range(0, 65535)), WAIT_MIN, WAIT_MAX,
                     16'($urandom_range(0, 65535)), 16'd1);
        send_idle_pct  = 14;
        recv_stall_pct = 14;
        send_random_requests(PHASE_ITEMS);
        drain();

        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
